[src/psc_pkg.sv]
// Shared types, codes and arithmetic helpers for the circle-actor physics block.
package psc_pkg;

  localparam int MAX_ACTORS_DEF = 8;
  localparam int CMPW = 5;
  localparam int DIV_NW = 49;
  localparam int DIV_DW = 32;
  localparam int CFG_IW = 2;
  localparam int Q16_SH = 16;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SETV = 3'd1;
  localparam logic [2:0] OP_SETF = 3'd2;
  localparam logic [2:0] OP_SETA = 3'd3;
  localparam logic [2:0] OP_STEP = 3'd4;

  localparam logic [2:0] KIND_ADDED = 3'd0;
  localparam logic [2:0] KIND_FULL  = 3'd1;
  localparam logic [2:0] KIND_SET   = 3'd2;
  localparam logic [2:0] KIND_UPD   = 3'd3;
  localparam logic [2:0] KIND_NONE  = 3'd4;

  localparam logic [CFG_IW-1:0] CFG_GX = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_GY = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_GZ = 2'd2;

  localparam logic [30:0] MASS_ONE = 31'h0001_0000;

  typedef logic signed [67:0] wide_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] frc;
    logic [30:0]      mass;
    logic [30:0]      rad;
  } rec_t;

  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -68'sd2147483648) r = 32'sh8000_0000;
    else r = 32'(v);
    return r;
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return m[31:0];
  endfunction

endpackage

[src/psc_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module psc_div #(
  parameter int NW = psc_pkg::DIV_NW,
  parameter int DW = psc_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW:0]     rem_r;
  logic [DW-1:0]   den_r;
  logic [NW-1:0]   q_r;
  logic [DW:0]     rem_sh;
  logic            ge;

  assign rem_sh = {rem_r[DW-1:0], q_r[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        den_r  <= den;
        q_r    <= num;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
        q_r   <= {q_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

[src/particle_step_circle_collision.sv]
// Top level of the circle-actor physics table: actor memory, step sequencer, result beats.
// Add and set-active pass decode, then a result beat; set velocity/force add a read-modify-write.
// Step: per active actor, velocity then position integration per axis (serial divider for force/mass),
// then a contact test per other actor, with serial root and divider push-out on contact, then emit.
// One item is worked at a time; the next is taken once the last beat is registered.
// Reset clears actor count, active flags, gravity and output valid; actor stores are undefined.
module particle_step_circle_collision #(
  parameter int MAX_ACTORS = psc_pkg::MAX_ACTORS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [psc_pkg::CFG_IW-1:0] cfg_addr,
  input  logic [31:0]               cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_op,
  input  logic [2:0]                in_actor,
  input  logic signed [31:0]        in_vec_x,
  input  logic signed [31:0]        in_vec_y,
  input  logic signed [31:0]        in_vec_z,
  input  logic [30:0]               in_amount,
  input  logic                      in_flag,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_kind,
  output logic [2:0]                out_slot,
  output logic signed [31:0]        out_pos_x,
  output logic signed [31:0]        out_pos_y,
  output logic signed [31:0]        out_pos_z,
  output logic [7:0]                out_contact_mask,
  output logic                      out_last
);
  localparam int IW = $clog2(MAX_ACTORS);
  localparam int CW = $clog2(MAX_ACTORS + 1);
  localparam int CMPW = psc_pkg::CMPW;
  localparam int NW = psc_pkg::DIV_NW;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_RMW, S_ONE, S_SCAN, S_LDI, S_VG, S_VA, S_VD, S_VM, S_VN,
    S_PM, S_PA, S_CJ, S_CD, S_CS0, S_CS1, S_CS2, S_CS3, S_CS4, S_SQ, S_ND, S_NW,
    S_NM, S_NA, S_EMIT
  } state_t;

  state_t                state_r;
  logic [2:0][31:0]      grav_r;
  logic [CW-1:0]         cnt_r;
  logic [MAX_ACTORS-1:0] act_r;

  logic [2:0]            op_r;
  logic [2:0]            a_r;
  logic [2:0][31:0]      vec_r;
  logic [30:0]           amt_r;
  logic                  flag_r;
  logic [2:0]            res_kind_r;
  logic [2:0]            res_slot_r;

  psc_pkg::rec_t         mem [MAX_ACTORS];
  psc_pkg::rec_t         mem_q;
  logic                  mem_we;
  logic [IW-1:0]         mem_wa;
  psc_pkg::rec_t         mem_wd;
  logic [IW-1:0]         mem_ra;

  psc_pkg::rec_t         wr_r;
  psc_pkg::rec_t         oth_r;
  logic [IW-1:0]         i_r;
  logic [CW-1:0]         j_r;
  logic [1:0]            k_r;
  logic signed [31:0]    vt_r;
  logic signed [31:0]    acc_r;
  logic [2:0][32:0]      d_r;
  logic [31:0]           rs_r;
  logic [65:0]           sum_r;
  logic [7:0]            mask_r;
  logic [63:0]           sq_rad_r;
  logic [34:0]           sq_rem_r;
  logic [31:0]           sq_root_r;
  logic [4:0]            sq_n_r;
  logic signed [17:0]    n_r;

  logic signed [32:0]    mul_a;
  logic signed [32:0]    mul_b;
  logic signed [65:0]    prod_r;
  logic signed [65:0]    psh;
  logic signed [31:0]    psat;

  logic                  div_start;
  logic [NW-1:0]         div_num;
  logic [31:0]           div_den;
  logic                  div_done;
  logic [NW-1:0]         div_q;
  psc_pkg::wide_t        qw;

  logic [IW-1:0]         last_idx;
  logic                  any_act;
  logic                  out_free;
  logic signed [31:0]    cur_v;
  logic signed [31:0]    cur_p;
  logic signed [31:0]    cur_f;
  logic signed [31:0]    cur_g;
  logic signed [31:0]    oth_p;
  logic signed [32:0]    cur_d;
  logic [34:0]           sq_sh;
  logic [34:0]           sq_trial;
  logic                  sq_ge;

  logic                  out_valid_r;
  logic [2:0]            out_kind_r;
  logic [2:0]            out_slot_r;
  logic [2:0][31:0]      out_pos_r;
  logic [7:0]            out_mask_r;
  logic                  out_last_r;

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  assign cur_v = $signed(wr_r.vel[k_r]);
  assign cur_p = $signed(wr_r.pos[k_r]);
  assign cur_f = $signed(wr_r.frc[k_r]);
  assign cur_g = $signed(grav_r[k_r]);
  assign oth_p = $signed(oth_r.pos[k_r]);
  assign cur_d = $signed(d_r[k_r]);

  assign psh  = prod_r >>> psc_pkg::Q16_SH;
  assign psat = psc_pkg::sat32(psc_pkg::wide_t'(psh));
  assign qw   = psc_pkg::wide_t'({19'd0, div_q});

  assign sq_sh    = {sq_rem_r[32:0], sq_rad_r[63:62]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  always_comb begin
    last_idx = '0;
    for (int b = 0; b < MAX_ACTORS; b++) begin
      if (act_r[b]) last_idx = IW'(b);
    end
  end
  assign any_act = |act_r;

  always_comb begin
    case (state_r)
      S_VG: begin
        mul_a = 33'(cur_g);
        mul_b = {2'b0, amt_r};
      end
      S_VM: begin
        mul_a = 33'(acc_r);
        mul_b = {2'b0, amt_r};
      end
      S_PM: begin
        mul_a = 33'(cur_v);
        mul_b = {2'b0, amt_r};
      end
      S_CS0: begin
        mul_a = {1'b0, psc_pkg::mag33(d_r[0])};
        mul_b = mul_a;
      end
      S_CS1: begin
        mul_a = {1'b0, psc_pkg::mag33(d_r[1])};
        mul_b = mul_a;
      end
      S_CS2: begin
        mul_a = {1'b0, psc_pkg::mag33(d_r[2])};
        mul_b = mul_a;
      end
      S_CS3: begin
        mul_a = {1'b0, rs_r};
        mul_b = mul_a;
      end
      S_NM: begin
        mul_a = 33'(n_r);
        mul_b = {1'b0, rs_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_r == S_VA && wr_r.mass != '0) begin
      div_start = 1'b1;
      div_num   = {1'b0, psc_pkg::mag33(33'(cur_f)), 16'd0};
      div_den   = {1'b0, wr_r.mass};
    end else if (state_r == S_ND && sq_root_r != '0) begin
      div_start = 1'b1;
      div_num   = {1'b0, psc_pkg::mag33(cur_d), 16'd0};
      div_den   = sq_root_r;
    end
  end

  psc_div #(.NW(NW), .DW(32)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = wr_r;
    mem_ra = '0;
    case (state_r)
      S_DEC: begin
        mem_ra = IW'(a_r);
        mem_wa = cnt_r[IW-1:0];
        mem_wd.pos  = vec_r;
        mem_wd.vel  = '0;
        mem_wd.frc  = '0;
        mem_wd.mass = psc_pkg::MASS_ONE;
        mem_wd.rad  = amt_r;
        mem_we = (op_r == psc_pkg::OP_ADD) && (cnt_r < CW'(MAX_ACTORS));
      end
      S_RMW: begin
        mem_we = 1'b1;
        mem_wa = IW'(a_r);
        mem_wd = mem_q;
        if (op_r == psc_pkg::OP_SETV) begin
          mem_wd.vel = vec_r;
        end else begin
          mem_wd.frc  = vec_r;
          mem_wd.mass = amt_r;
        end
      end
      S_SCAN: mem_ra = i_r;
      S_CJ:   mem_ra = j_r[IW-1:0];
      S_EMIT: begin
        mem_we = out_free;
        mem_wa = i_r;
      end
      default: mem_ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        psc_pkg::CFG_GX: grav_r[0] <= cfg_wdata;
        psc_pkg::CFG_GY: grav_r[1] <= cfg_wdata;
        psc_pkg::CFG_GZ: grav_r[2] <= cfg_wdata;
        default: grav_r <= grav_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_op;
            a_r      <= in_actor;
            vec_r    <= {in_vec_z, in_vec_y, in_vec_x};
            amt_r    <= in_amount;
            flag_r   <= in_flag;
            state_r  <= S_DEC;
          end
        end
        S_DEC: begin
          res_kind_r <= psc_pkg::KIND_SET;
          res_slot_r <= a_r;
          state_r    <= S_ONE;
          case (op_r)
            psc_pkg::OP_ADD: begin
              if (cnt_r < CW'(MAX_ACTORS)) begin
                res_kind_r <= psc_pkg::KIND_ADDED;
                res_slot_r <= 3'(cnt_r);
                cnt_r      <= cnt_r + 1'b1;
              end else begin
                res_kind_r <= psc_pkg::KIND_FULL;
                res_slot_r <= '0;
              end
            end
            psc_pkg::OP_SETV, psc_pkg::OP_SETF: begin
              if (CMPW'(a_r) < CMPW'(cnt_r)) state_r <= S_RMW;
            end
            psc_pkg::OP_SETA: begin
              if (CMPW'(a_r) < CMPW'(cnt_r)) act_r[IW'(a_r)] <= flag_r;
            end
            psc_pkg::OP_STEP: begin
              if (any_act) begin
                i_r     <= '0;
                state_r <= S_SCAN;
              end else begin
                res_kind_r <= psc_pkg::KIND_NONE;
                res_slot_r <= '0;
              end
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_RMW: state_r <= S_ONE;
        S_ONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_slot_r  <= res_slot_r;
            out_pos_r   <= (res_kind_r == psc_pkg::KIND_ADDED) ? vec_r : '0;
            out_mask_r  <= '0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (act_r[i_r]) state_r <= S_LDI;
          else i_r <= i_r + 1'b1;
        end
        S_LDI: begin
          wr_r    <= mem_q;
          k_r     <= '0;
          state_r <= S_VG;
        end
        S_VG: state_r <= S_VA;
        S_VA: begin
          vt_r <= psc_pkg::sat32(psc_pkg::wide_t'(cur_v) + psc_pkg::wide_t'(psat));
          if (wr_r.mass != '0) begin
            state_r <= S_VD;
          end else begin
            acc_r   <= '0;
            state_r <= S_VM;
          end
        end
        S_VD: begin
          if (div_done) begin
            acc_r   <= psc_pkg::sat32(cur_f[31] ? -qw : qw);
            state_r <= S_VM;
          end
        end
        S_VM: state_r <= S_VN;
        S_VN: begin
          wr_r.vel[k_r] <= psc_pkg::sat32(psc_pkg::wide_t'(vt_r) + psc_pkg::wide_t'(psat));
          if (k_r == 2'd2) begin
            k_r     <= '0;
            state_r <= S_PM;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_VG;
          end
        end
        S_PM: state_r <= S_PA;
        S_PA: begin
          wr_r.pos[k_r] <= psc_pkg::sat32(psc_pkg::wide_t'(cur_p) + psc_pkg::wide_t'(psat));
          if (k_r == 2'd2) begin
            k_r     <= '0;
            j_r     <= '0;
            mask_r  <= '0;
            state_r <= S_CJ;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PM;
          end
        end
        S_CJ: begin
          if (j_r == cnt_r) state_r <= S_EMIT;
          else if (j_r[IW-1:0] == i_r) j_r <= j_r + 1'b1;
          else state_r <= S_CD;
        end
        S_CD: begin
          oth_r <= mem_q;
          for (int c = 0; c < 3; c++) begin
            d_r[c] <= 33'($signed(wr_r.pos[c])) - 33'($signed(mem_q.pos[c]));
          end
          rs_r    <= {1'b0, wr_r.rad} + {1'b0, mem_q.rad};
          state_r <= S_CS0;
        end
        S_CS0: state_r <= S_CS1;
        S_CS1: begin
          sum_r   <= prod_r;
          state_r <= S_CS2;
        end
        S_CS2: begin
          sum_r   <= sum_r + prod_r;
          state_r <= S_CS3;
        end
        S_CS3: begin
          sum_r   <= sum_r + prod_r;
          state_r <= S_CS4;
        end
        S_CS4: begin
          if (sum_r < prod_r) begin
            sq_rad_r  <= sum_r[63:0];
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            sq_n_r    <= '0;
            state_r   <= S_SQ;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_CJ;
          end
        end
        S_SQ: begin
          sq_rem_r  <= sq_ge ? sq_sh - sq_trial : sq_sh;
          sq_root_r <= {sq_root_r[30:0], sq_ge};
          sq_rad_r  <= {sq_rad_r[61:0], 2'b00};
          sq_n_r    <= sq_n_r + 1'b1;
          if (sq_n_r == 5'd31) begin
            k_r     <= '0;
            state_r <= S_ND;
          end
        end
        S_ND: begin
          if (sq_root_r != '0) begin
            state_r <= S_NW;
          end else begin
            n_r     <= '0;
            state_r <= S_NM;
          end
        end
        S_NW: begin
          if (div_done) begin
            n_r     <= 18'(cur_d[32] ? -qw : qw);
            state_r <= S_NM;
          end
        end
        S_NM: state_r <= S_NA;
        S_NA: begin
          wr_r.pos[k_r] <= psc_pkg::sat32(psc_pkg::wide_t'(oth_p) + psc_pkg::wide_t'(psh));
          if (k_r == 2'd2) begin
            for (int b = 0; b < 8; b++) begin
              if (CMPW'(j_r) == CMPW'(b)) mask_r[b] <= 1'b1;
            end
            j_r     <= j_r + 1'b1;
            state_r <= S_CJ;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_ND;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= psc_pkg::KIND_UPD;
            out_slot_r  <= 3'(i_r);
            out_pos_r   <= wr_r.pos;
            out_mask_r  <= mask_r;
            out_last_r  <= (i_r == last_idx);
            if (i_r == last_idx) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_SCAN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_slot         = out_slot_r;
  assign out_pos_x        = out_pos_r[0];
  assign out_pos_y        = out_pos_r[1];
  assign out_pos_z        = out_pos_r[2];
  assign out_contact_mask = out_mask_r;
  assign out_last         = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ACTORS))
    else $error("actor count beyond table depth");

  a_act_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r >> cnt_r) == '0)
    else $error("active flag set outside the table");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == psc_pkg::KIND_NONE |-> out_last_r)
    else $error("nothing-active beat not marked last");

  a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && out_free && i_r == last_idx |=> state_r == S_IDLE && out_last_r)
    else $error("final actor beat did not end the step");
endmodule

[bench/testbench.sv]
// Testbench for the circle-actor physics table: random and directed items checked against a predictor.
`timescale 1ns / 1ps

typedef struct {
  logic [2:0]         op;
  logic [2:0]         actor;
  logic signed [31:0] vec [3];
  logic [30:0]        amount;
  logic               flag;
} item_t;

typedef struct {
  logic [2:0]  kind;
  logic [2:0]  slot;
  logic [31:0] px;
  logic [31:0] py;
  logic [31:0] pz;
  logic [7:0]  mask;
  logic        last;
} beat_t;

class physics_scoreboard;
  longint      grav [3];
  int unsigned count;
  bit          active [8];
  longint      pos [8][3];
  longint      vel [8][3];
  longint      frc [8][3];
  longint      mass [8];
  longint      rad [8];
  beat_t       pending_beats [$];

  function new();
    count = 0;
    for (int k = 0; k < 3; k++) grav[k] = 0;
    for (int i = 0; i < 8; i++) active[i] = 0;
  endfunction

  function void set_gravity(int k, logic [31:0] v);
    grav[k] = longint'(signed'(v));
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function logic [63:0] root64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function longint integrate_vel(longint v, longint g, longint f, longint m, longint dt);
    longint acc;
    acc = 0;
    v = clamp32(v + clamp32(qmul(g, dt)));
    if (m > 0) acc = clamp32((f * 65536) / m);
    return clamp32(v + clamp32(qmul(acc, dt)));
  endfunction

  function logic [7:0] push_out(int i);
    logic [7:0]  mask;
    longint      d [3];
    longint      n [3];
    longint      a;
    longint      rs;
    logic [67:0] s;
    logic [67:0] w;
    logic [67:0] rs2;
    logic [63:0] root_len;
    mask = 0;
    for (int j = 0; j < count; j++) begin
      if (j == i) continue;
      s = 0;
      for (int k = 0; k < 3; k++) begin
        d[k] = pos[i][k] - pos[j][k];
        a = d[k] < 0 ? -d[k] : d[k];
        w = 68'(a);
        s = s + w * w;
      end
      rs = rad[i] + rad[j];
      w = 68'(rs);
      rs2 = w * w;
      if (s >= rs2) continue;
      root_len = root64(s[63:0]);
      for (int k = 0; k < 3; k++) begin
        n[k] = (root_len != 0) ? (d[k] * 65536) / longint'(root_len) : 0;
        pos[i][k] = clamp32(pos[j][k] + qmul(n[k], rs));
      end
      mask[j] = 1'b1;
    end
    return mask;
  endfunction

  function void push_beat(logic [2:0] kind, int slot, longint x, longint y, longint z,
                          logic [7:0] mask);
    beat_t b;
    b.kind = kind;
    b.slot = 3'(slot);
    b.px = x[31:0];
    b.py = y[31:0];
    b.pz = z[31:0];
    b.mask = mask;
    b.last = 1'b0;
    pending_beats.push_back(b);
  endfunction

  function void note_item(item_t it);
    int         a;
    int         emitted;
    longint     dt;
    logic [7:0] mask;
    a = it.actor;
    dt = longint'(it.amount);
    emitted = 0;
    case (it.op)
      psc_pkg::OP_ADD: begin
        if (count < 8) begin
          for (int k = 0; k < 3; k++) begin
            pos[count][k] = it.vec[k];
            vel[count][k] = 0;
            frc[count][k] = 0;
          end
          mass[count] = 65536;
          rad[count] = dt;
          active[count] = 0;
          push_beat(psc_pkg::KIND_ADDED, count, it.vec[0], it.vec[1], it.vec[2], 0);
          count++;
        end else begin
          push_beat(psc_pkg::KIND_FULL, 0, 0, 0, 0, 0);
        end
        emitted = 1;
      end
      psc_pkg::OP_SETV, psc_pkg::OP_SETF, psc_pkg::OP_SETA: begin
        if (a < count) begin
          if (it.op == psc_pkg::OP_SETV) begin
            for (int k = 0; k < 3; k++) vel[a][k] = it.vec[k];
          end else if (it.op == psc_pkg::OP_SETF) begin
            for (int k = 0; k < 3; k++) frc[a][k] = it.vec[k];
            mass[a] = dt;
          end else begin
            active[a] = it.flag;
          end
        end
        push_beat(psc_pkg::KIND_SET, a, 0, 0, 0, 0);
        emitted = 1;
      end
      psc_pkg::OP_STEP: begin
        for (int i = 0; i < count; i++) begin
          if (!active[i]) continue;
          for (int k = 0; k < 3; k++)
            vel[i][k] = integrate_vel(vel[i][k], grav[k], frc[i][k], mass[i], dt);
          for (int k = 0; k < 3; k++)
            pos[i][k] = clamp32(pos[i][k] + clamp32(qmul(vel[i][k], dt)));
          mask = push_out(i);
          push_beat(psc_pkg::KIND_UPD, i, pos[i][0], pos[i][1], pos[i][2], mask);
          emitted++;
        end
        if (emitted == 0) begin
          push_beat(psc_pkg::KIND_NONE, 0, 0, 0, 0, 0);
          emitted = 1;
        end
      end
      default: ;
    endcase
    if (emitted != 0) pending_beats[pending_beats.size() - 1].last = 1'b1;
  endfunction

  function bit check_beat(beat_t got, output string msg);
    beat_t e;
    if (pending_beats.size() == 0) begin
      $sformat(msg, "unexpected beat kind %0d slot %0d", got.kind, got.slot);
      return 0;
    end
    e = pending_beats.pop_front();
    if (got.kind !== e.kind || got.slot !== e.slot || got.px !== e.px || got.py !== e.py ||
        got.pz !== e.pz || got.mask !== e.mask || got.last !== e.last) begin
      $sformat(msg, "got k%0d s%0d %h %h %h m%h l%0d, want k%0d s%0d %h %h %h m%h l%0d",
               got.kind, got.slot, got.px, got.py, got.pz, got.mask, got.last,
               e.kind, e.slot, e.px, e.py, e.pz, e.mask, e.last);
      return 0;
    end
    return 1;
  endfunction
endclass

module testbench;
  localparam longint LIMIT = 64'd8_000_000;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [psc_pkg::CFG_IW-1:0] cfg_addr;
  logic [31:0]                cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic [2:0]                 in_op;
  logic [2:0]                 in_actor;
  logic signed [31:0]         in_vec_x;
  logic signed [31:0]         in_vec_y;
  logic signed [31:0]         in_vec_z;
  logic [30:0]                in_amount;
  logic                       in_flag;
  logic                       out_valid;
  logic                       out_ready;
  logic [2:0]                 out_kind;
  logic [2:0]                 out_slot;
  logic signed [31:0]         out_pos_x;
  logic signed [31:0]         out_pos_y;
  logic signed [31:0]         out_pos_z;
  logic [7:0]                 out_contact_mask;
  logic                       out_last;

  physics_scoreboard sb;
  int                errors;
  longint            cycles;
  int                stall_mode;
  int                stall_left;
  int                burst_left;

  particle_step_circle_collision dut (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    beat_t b;
    string msg;
    if (rst_n && out_valid && out_ready) begin
      b.kind = out_kind;
      b.slot = out_slot;
      b.px = out_pos_x;
      b.py = out_pos_y;
      b.pz = out_pos_z;
      b.mask = out_contact_mask;
      b.last = out_last;
      if (!sb.check_beat(b, msg)) report(msg);
    end
  end

  always @(negedge clk) begin
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= (cycles % 5 < 3);
      default: begin
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 30);
        end
      end
    endcase
  end

  task automatic send_item(item_t it);
    @(negedge clk);
    in_op = it.op;
    in_actor = it.actor;
    in_vec_x = it.vec[0];
    in_vec_y = it.vec[1];
    in_vec_z = it.vec[2];
    in_amount = it.amount;
    in_flag = it.flag;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 10);
      repeat ($urandom_range(0, 8)) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
  endtask

  task automatic send(logic [2:0] op, logic [2:0] actor, logic [31:0] x, logic [31:0] y,
                      logic [31:0] z, logic [30:0] amount, logic flag);
    item_t it;
    it.op = op;
    it.actor = actor;
    it.vec[0] = x;
    it.vec[1] = y;
    it.vec[2] = z;
    it.amount = amount;
    it.flag = flag;
    send_item(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_gravity(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz);
    logic [31:0] g [3];
    g[0] = gx;
    g[1] = gy;
    g[2] = gz;
    @(negedge clk);
    in_valid = 1'b0;
    for (int k = 0; k < 3; k++) begin
      cfg_we = 1'b1;
      cfg_addr = k[psc_pkg::CFG_IW-1:0];
      cfg_wdata = g[k];
      sb.set_gravity(k, g[k]);
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    if (sel < 8) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [30:0] rand_amount(int unsigned small_max);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 31'($urandom_range(0, small_max));
    if (sel < 9) return 31'($urandom);
    return sel[0] ? 31'h7FFF_FFFF : 31'h0;
  endfunction

  task automatic random_items(int n);
    item_t it;
    int    sel;
    int    sent;
    sent = 0;
    while (sent < n) begin
      sel = $urandom_range(0, 99);
      it.actor = 3'($urandom_range(0, 7));
      it.vec[0] = rand_coord();
      it.vec[1] = rand_coord();
      it.vec[2] = rand_coord();
      it.flag = ($urandom_range(0, 9) < 7);
      it.amount = rand_amount(32'h0002_0000);
      if (sel < 10) begin
        it.op = psc_pkg::OP_ADD;
      end else if (sel < 25) begin
        it.op = psc_pkg::OP_SETV;
        it.vec[0] = 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      end else if (sel < 40) begin
        it.op = psc_pkg::OP_SETF;
      end else if (sel < 58) begin
        it.op = psc_pkg::OP_SETA;
      end else if (sel < 96) begin
        it.op = psc_pkg::OP_STEP;
        it.amount = rand_amount(32'h0000_8000);
      end else begin
        it.op = 3'($urandom_range(5, 7));
      end
      send_item(it);
      if (it.op <= psc_pkg::OP_STEP) sent++;
    end
  endtask

  initial begin
    sb = new();
    stall_mode = 0;
    burst_left = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_op = '0;
    in_actor = '0;
    in_vec_x = '0;
    in_vec_y = '0;
    in_vec_z = '0;
    in_amount = '0;
    in_flag = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(psc_pkg::OP_STEP, 0, 0, 0, 0, 31'h1_0000, 0);
    send(psc_pkg::OP_SETV, 3, 32'h1234, 32'h5678, 32'h9ABC, 0, 0);
    send(psc_pkg::OP_SETA, 7, 0, 0, 0, 0, 1);
    send(psc_pkg::OP_ADD, 0, 0, 0, 0, 31'h1_0000, 0);
    send(psc_pkg::OP_ADD, 0, 32'h1_8000, 0, 0, 31'h1_0000, 0);
    send(psc_pkg::OP_ADD, 0, 0, 0, 0, 0, 0);
    send(psc_pkg::OP_ADD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1);
    send(psc_pkg::OP_SETA, 0, 0, 0, 0, 0, 1);
    send(psc_pkg::OP_SETA, 2, 0, 0, 0, 0, 1);
    send(psc_pkg::OP_SETF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1_0000, 0, 0);
    send(psc_pkg::OP_SETV, 2, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
    send(psc_pkg::OP_STEP, 0, 0, 0, 0, 0, 0);
    send(psc_pkg::OP_STEP, 0, 0, 0, 0, 31'h7FFF_FFFF, 0);
    send(psc_pkg::OP_SETF, 2, 32'h0003_0000, 32'hFFFD_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
    send(3'd5, 0, 0, 0, 0, 0, 0);
    send(3'd6, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1);
    send(3'd7, 0, 0, 0, 0, 0, 0);
    send(psc_pkg::OP_SETA, 3, 0, 0, 0, 0, 1);
    send(psc_pkg::OP_SETA, 0, 0, 0, 0, 0, 0);
    send(psc_pkg::OP_STEP, 0, 0, 0, 0, 31'h8000, 0);
    drain();

    set_gravity(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send(psc_pkg::OP_STEP, 0, 0, 0, 0, 31'h100, 0);
    stall_mode = 1;
    random_items(50);
    drain();

    set_gravity(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    stall_mode = 3;
    random_items(50);
    drain();

    set_gravity($urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
                $urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
                $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
    stall_mode = 2;
    random_items(45);
    drain();

    set_gravity(32'h0, 32'hFFF6_0000, 32'h0);
    stall_mode = 0;
    random_items(40);
    drain();

    if (sb.pending_beats.size() != 0)
      report($sformatf("%0d expected beats never arrived", sb.pending_beats.size()));
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[particle_step_circle_collision.f]
src/psc_pkg.sv
src/psc_div.sv
src/particle_step_circle_collision.sv
bench/testbench.sv
